// ----- src/pwrp_pkg.sv -----
// Shared types and constants for the plot window reply parser.
// No dependencies; imported by every module of the block.
package pwrp_pkg;

    // Drawing area size after reset
    localparam logic [15:0] SIZE_X_RESET = 16'd11880;
    localparam logic [15:0] SIZE_Y_RESET = 16'd8400;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // One result item
    typedef struct packed {
        logic        accepted;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] size_x;
        logic [15:0] size_y;
    } pwrp_result_t;

endpackage

// ----- src/pwrp_parser.sv -----
// Byte parser: decimal accumulate, field sequencing and window check.
// Depends on pwrp_pkg.
module pwrp_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic [7:0]             rx_byte,
    output logic                   res_valid,
    output pwrp_pkg::pwrp_result_t res
);
    import pwrp_pkg::*;

    typedef enum logic [1:0] {FIELD_X0, FIELD_Y0, FIELD_X1, FIELD_Y1} field_t;

    field_t      field_reg, field_next;
    logic [15:0] accum_reg, accum_next;
    logic        seen_reg, seen_next;
    logic [15:0] x0_reg, x0_next;
    logic [15:0] y0_reg, y0_next;
    logic [15:0] x1_reg, x1_next;
    logic [15:0] size_x_reg, size_x_next;
    logic [15:0] size_y_reg, size_y_next;

    logic        is_digit;
    logic        ends_num;
    logic [3:0]  digit;
    logic [15:0] accum_dec;
    logic [15:0] width;
    logic [15:0] height;
    logic        ok;

    // Byte classification and value*10+digit, wrapping at 16 bits
    assign is_digit  = (rx_byte inside {[CH_ZERO:CH_NINE]});
    assign ends_num  = (rx_byte == CH_NEWLINE) && seen_reg;
    assign digit     = 4'(rx_byte - CH_ZERO);
    assign accum_dec = {accum_reg[12:0], 3'b000} + {accum_reg[14:0], 1'b0}
                     + {12'd0, digit};

    // Window check on x0, y0, x1 and the y1 in the accumulator
    assign width  = x1_reg - x0_reg;
    assign height = accum_reg - y0_reg;
    assign ok     = (x1_reg > x0_reg) && (accum_reg > y0_reg)
                 && (width <= size_x_reg) && (height <= size_y_reg);

    // Next state
    always_comb
    begin
        field_next  = field_reg;
        accum_next  = accum_reg;
        seen_next   = seen_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        x1_next     = x1_reg;
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        res_valid   = 1'b0;
        if (in_fire)
        begin
            if (is_digit)
            begin
                accum_next = accum_dec;
                seen_next  = 1'b1;
            end
            else if (ends_num)
            begin
                accum_next = '0;
                seen_next  = 1'b0;
                case (field_reg)
                    FIELD_X0:
                    begin
                        x0_next    = accum_reg;
                        field_next = FIELD_Y0;
                    end
                    FIELD_Y0:
                    begin
                        y0_next    = accum_reg;
                        field_next = FIELD_X1;
                    end
                    FIELD_X1:
                    begin
                        x1_next    = accum_reg;
                        field_next = FIELD_Y1;
                    end
                    default:
                    begin
                        field_next = FIELD_X0;
                        res_valid  = 1'b1;
                        if (ok)
                        begin
                            size_x_next = width;
                            size_y_next = height;
                        end
                    end
                endcase
            end
        end
    end

    // Result item, carrying the sizes as they stand after this reply
    always_comb
    begin
        res.accepted = ok;
        res.origin_x = x0_reg;
        res.origin_y = y0_reg;
        res.size_x   = size_x_next;
        res.size_y   = size_y_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg  <= FIELD_X0;
            accum_reg  <= '0;
            seen_reg   <= 1'b0;
            x0_reg     <= '0;
            y0_reg     <= '0;
            x1_reg     <= '0;
            size_x_reg <= SIZE_X_RESET;
            size_y_reg <= SIZE_Y_RESET;
        end
        else
        begin
            field_reg  <= field_next;
            accum_reg  <= accum_next;
            seen_reg   <= seen_next;
            x0_reg     <= x0_next;
            y0_reg     <= y0_next;
            x1_reg     <= x1_next;
            size_x_reg <= size_x_next;
            size_y_reg <= size_y_next;
        end
    end

endmodule

// ----- src/pwrp_out_buf.sv -----
// Two-entry output buffer (result register plus skid register).
// Depends on pwrp_pkg.
module pwrp_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pwrp_pkg::pwrp_result_t push_data,
    output logic                   space,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pwrp_pkg::pwrp_result_t out_data
);
    import pwrp_pkg::*;

    logic         main_valid_reg;
    logic         skid_valid_reg;
    pwrp_result_t main_reg;
    pwrp_result_t skid_reg;
    logic         pop;

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    // Control: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                main_valid_reg <= push;
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= push_data;
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

endmodule

// ----- src/plot_window_reply_parser_unit.sv -----
// Top level of the plot window reply parser.
// Depends on pwrp_pkg, pwrp_parser and pwrp_out_buf.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | rx_byte
//  out     | out_valid / out_ready | accepted, origin_x, origin_y,
//          |                       | size_x_out, size_y_out
//
// One byte item is taken every cycle while in_ready is high; the parse step
// and window check sit between the input port and the output buffer, so the
// result for the newline that ends y1 is registered there. A two-entry result
// buffer lets items keep flowing while one result waits at the output; in_ready
// drops only once both entries hold results. Reset restores the default drawing area.
module plot_window_reply_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [15:0] origin_x,
    output logic [15:0] origin_y,
    output logic [15:0] size_x_out,
    output logic [15:0] size_y_out
);
    import pwrp_pkg::*;

    logic         in_fire;
    logic         res_valid;
    pwrp_result_t res;
    pwrp_result_t out_data;

    assign in_fire = in_valid && in_ready;

    pwrp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    pwrp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign accepted   = out_data.accepted;
    assign origin_x   = out_data.origin_x;
    assign origin_y   = out_data.origin_y;
    assign size_x_out = out_data.size_x;
    assign size_y_out = out_data.size_y;

`ifndef SYNTHESIS
    // A result only comes from an accepted item
    a_res_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_fire)
        else $error("result raised without an accepted item");

    // Input back-pressure only while a result is on show
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // An applied window always has non-zero size
    a_applied_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.accepted |-> (res.size_x != 16'd0) && (res.size_y != 16'd0))
        else $error("applied window with zero size");

    // A result just pushed into an empty buffer is shown next cycle
    a_push_shown: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |=> out_valid)
        else $error("pushed result not presented");
`endif

endmodule
